// ----- hdl/shbe_pkg.sv -----
package shbe_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef logic signed [15:0] comp_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [35:0] quad_t;
  typedef logic signed [16:0] lin_t;
  typedef logic signed [26:0] coef_t;

  // one direction with its quadratic forms, ready for the back end
  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    quad_t xy;
    quad_t yz;
    quad_t zx;
    quad_t q6;
    quad_t q8;
    quad_t q9;
    quad_t q11;
    quad_t q12;
    quad_t q15;
    logic [4:0] words;
  } dir_entry_t;

  typedef struct packed {
    logic       valid;
    dir_entry_t entry;
  } qin_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam logic [2:0] MAX_BANDS = 3'd4;

  function automatic logic [4:0] band_words(input logic [2:0] bands);
    logic [4:0] n;
    case (bands)
      3'd0: n = 5'd0;
      3'd1: n = 5'd1;
      3'd2: n = 5'd4;
      3'd3: n = 5'd9;
      default: n = 5'd16;
    endcase
    return n;
  endfunction

  function automatic quad_t ext_q(input prod_t v);
    return {{4{v[31]}}, v};
  endfunction

  // Q.24 constants with the 0.5 / 0.25 factor and sign folded in
  function automatic coef_t basis_const(input logic [3:0] k);
    coef_t c;
    case (k)
      4'd0:  c = 27'sd4732765;
      4'd1:  c = -27'sd8197390;
      4'd2:  c = 27'sd8197390;
      4'd3:  c = -27'sd8197390;
      4'd4:  c = 27'sd18329921;
      4'd5:  c = -27'sd18329921;
      4'd6:  c = 27'sd5291392;
      4'd7:  c = -27'sd18329921;
      4'd8:  c = 27'sd9164961;
      4'd9:  c = -27'sd9899289;
      4'd10: c = 27'sd48496413;
      4'd11: c = -27'sd7667956;
      4'd12: c = 27'sd6260860;
      4'd13: c = -27'sd7667956;
      4'd14: c = 27'sd24248206;
      default: c = -27'sd9899289;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/shbe_front.sv -----
module shbe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  shbe_pkg::comp_t    dir_x,
  input  shbe_pkg::comp_t    dir_y,
  input  shbe_pkg::comp_t    dir_z,
  input  logic [2:0]         band_count,
  input  shbe_pkg::qstat_t   q_stat,
  output shbe_pkg::qin_t     q_in
);
  import shbe_pkg::*;

  logic       f1_valid;
  comp_t      f1_x, f1_y, f1_z;
  logic [4:0] f1_words;

  logic       f2_valid;
  comp_t      f2_x, f2_y, f2_z;
  prod_t      f2_xx, f2_yy, f2_zz, f2_xy, f2_yz, f2_zx;
  logic [4:0] f2_words;

  logic       f2_done, f2_free, f1_free, accept;
  logic [2:0] bands;
  quad_t      sx, sy, sz, sx3, sy3;

  // a direction with no bands is dropped here and never queued
  assign f2_done  = f2_valid && ((f2_words == 5'd0) || !q_stat.full);
  assign f2_free  = !f2_valid || f2_done;
  assign f1_free  = !f1_valid || f2_free;
  assign in_stall = !f1_free;
  assign accept   = in_valid && f1_free;
  assign bands    = (band_count > MAX_BANDS) ? MAX_BANDS : band_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_free) f1_valid <= in_valid;
      if (f2_free) f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_x     <= dir_x;
      f1_y     <= dir_y;
      f1_z     <= dir_z;
      f1_words <= band_words(bands);
    end
    if (f2_free && f1_valid) begin
      f2_x     <= f1_x;
      f2_y     <= f1_y;
      f2_z     <= f1_z;
      f2_xx    <= f1_x * f1_x;
      f2_yy    <= f1_y * f1_y;
      f2_zz    <= f1_z * f1_z;
      f2_xy    <= f1_x * f1_y;
      f2_yz    <= f1_y * f1_z;
      f2_zx    <= f1_z * f1_x;
      f2_words <= f1_words;
    end
  end

  always_comb begin
    sx  = ext_q(f2_xx);
    sy  = ext_q(f2_yy);
    sz  = ext_q(f2_zz);
    sx3 = (sx <<< 1) + sx;
    sy3 = (sy <<< 1) + sy;
    q_in.valid       = f2_valid && (f2_words != 5'd0) && !q_stat.full;
    q_in.entry.x     = f2_x;
    q_in.entry.y     = f2_y;
    q_in.entry.z     = f2_z;
    q_in.entry.xy    = ext_q(f2_xy);
    q_in.entry.yz    = ext_q(f2_yz);
    q_in.entry.zx    = ext_q(f2_zx);
    q_in.entry.q6    = (sz <<< 1) - sx - sy;
    q_in.entry.q8    = sx - sy;
    q_in.entry.q9    = sx3 - sy;
    q_in.entry.q11   = (sz <<< 2) - sx - sy;
    q_in.entry.q12   = (sz <<< 1) - sx3 - sy3;
    q_in.entry.q15   = sx - sy3;
    q_in.entry.words = f2_words;
  end

endmodule

// ----- hdl/shbe_queue.sv -----
module shbe_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  shbe_pkg::qin_t       q_in,
  input  logic                 pop,
  output shbe_pkg::qstat_t     q_stat,
  output shbe_pkg::dir_entry_t head
);
  import shbe_pkg::*;

  dir_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_in.valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop)        rd_ptr <= rd_ptr + 1'b1;
      if (q_in.valid && !pop)      count <= count + 1'b1;
      else if (!q_in.valid && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_in.valid) slots[wr_ptr] <= q_in.entry;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_in.valid |-> !q_stat.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (q_in.valid && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

// ----- hdl/shbe_back.sv -----
module shbe_back (
  input  logic                 clk,
  input  logic                 rst,
  input  shbe_pkg::dir_entry_t head,
  input  shbe_pkg::qstat_t     q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           coeff_index,
  output shbe_pkg::comp_t      basis_value,
  output logic                 last_coeff
);
  import shbe_pkg::*;

  localparam lin_t  LIN_ONE  = 17'sd32768;
  localparam quad_t QUAD_ONE = 36'sd1073741824;

  logic [3:0] k;
  logic       en, issue, last;
  lin_t       sel_v;
  quad_t      sel_w;
  logic signed [52:0] full_prod;

  logic               b1_valid, b1_last;
  logic [3:0]         b1_k;
  logic signed [48:0] b1_prod;

  logic               b2_valid, b2_last;
  logic [3:0]         b2_k;
  logic signed [34:0] b2_p30;
  coef_t              b2_c;
  logic signed [49:0] p30_sum;

  logic               b3_valid, b3_last;
  logic [3:0]         b3_k;
  logic signed [61:0] b3_m;
  logic signed [62:0] r_sum;
  logic signed [23:0] r_full;
  comp_t              r_sat;

  assign en    = !out_valid || !out_stall;
  assign issue = en && !q_stat.empty;
  assign last  = ({1'b0, k} == (head.words - 5'd1));
  assign pop   = issue && last;

  // every term is brought to Q45 as lin * quad so one rounding path serves all
  always_comb begin
    case (k)
      4'd0:  begin sel_v = LIN_ONE;          sel_w = QUAD_ONE;  end
      4'd1:  begin sel_v = {head.y[15], head.y}; sel_w = QUAD_ONE; end
      4'd2:  begin sel_v = {head.z[15], head.z}; sel_w = QUAD_ONE; end
      4'd3:  begin sel_v = {head.x[15], head.x}; sel_w = QUAD_ONE; end
      4'd4:  begin sel_v = LIN_ONE;          sel_w = head.xy;   end
      4'd5:  begin sel_v = LIN_ONE;          sel_w = head.yz;   end
      4'd6:  begin sel_v = LIN_ONE;          sel_w = head.q6;   end
      4'd7:  begin sel_v = LIN_ONE;          sel_w = head.zx;   end
      4'd8:  begin sel_v = LIN_ONE;          sel_w = head.q8;   end
      4'd9:  begin sel_v = {head.y[15], head.y}; sel_w = head.q9;  end
      4'd10: begin sel_v = {head.z[15], head.z}; sel_w = head.xy;  end
      4'd11: begin sel_v = {head.y[15], head.y}; sel_w = head.q11; end
      4'd12: begin sel_v = {head.z[15], head.z}; sel_w = head.q12; end
      4'd13: begin sel_v = {head.x[15], head.x}; sel_w = head.q11; end
      4'd14: begin sel_v = {head.z[15], head.z}; sel_w = head.q8;  end
      default: begin sel_v = {head.x[15], head.x}; sel_w = head.q15; end
    endcase
  end

  assign full_prod = sel_v * sel_w;
  // round Q45 to Q30, half up
  assign p30_sum   = {b1_prod[48], b1_prod} + 50'sd16384;
  // round Q54 to Q15, half up, then saturate
  assign r_sum     = {b3_m[61], b3_m} + 63'sd274877906944;
  assign r_full    = r_sum[62:39];

  always_comb begin
    if (r_full > 24'sd32767)       r_sat = 16'sh7fff;
    else if (r_full < -24'sd32768) r_sat = 16'sh8000;
    else                           r_sat = r_full[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= issue;
      b2_valid  <= b1_valid;
      b3_valid  <= b2_valid;
      out_valid <= b3_valid;
      if (issue) k <= last ? 4'd0 : k + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_k        <= k;
      b1_last     <= last;
      b1_prod     <= full_prod[48:0];
      b2_k        <= b1_k;
      b2_last     <= b1_last;
      b2_p30      <= p30_sum[49:15];
      b2_c        <= basis_const(b1_k);
      b3_k        <= b2_k;
      b3_last     <= b2_last;
      b3_m        <= b2_c * b2_p30;
      coeff_index <= b3_k;
      last_coeff  <= b3_last;
      basis_value <= r_sat;
    end
  end

`ifndef SYNTHESIS
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (k == 4'd0)) else $error("index not restarted after last word");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (issue && !last) |=> (k == $past(k) + 4'd1)) else $error("index skipped");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(b3_m) && $stable(b1_prod))) else $error("pipe moved on stall");
`endif

endmodule

// ----- hdl/sh_basis_eval_unit.sv -----
// channel  direction  handshake              word
// in       input      in_valid / in_stall    dir_x, dir_y, dir_z
// out      output     out_valid / out_stall  coeff_index, basis_value, last_coeff
// cfg      input      cfg_valid / cfg_ready  cfg_data (band_count)
//
// a direction gives band_count squared words (band_count capped at four, so 16 at
// four bands or more) at one word per cycle unless out_stall holds the back end;
// the back-end index sequencer sets the rate.
// reset is synchronous: clears queue, pipes and sets band_count to four
// out_stall freezes the back end; the four-entry queue and the two front stages
// keep taking directions until they fill, then in_stall rises
module sh_basis_eval_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  shbe_pkg::comp_t dir_x,
  input  shbe_pkg::comp_t dir_y,
  input  shbe_pkg::comp_t dir_z,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [3:0]      coeff_index,
  output shbe_pkg::comp_t basis_value,
  output logic            last_coeff,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_data
);
  import shbe_pkg::*;

  logic [2:0] band_count;
  qin_t       q_in;
  qstat_t     q_stat;
  dir_entry_t head;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_count <= MAX_BANDS;
    end else if (cfg_valid && cfg_ready) begin
      band_count <= cfg_data;
    end
  end

  shbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .band_count (band_count),
    .q_stat     (q_stat),
    .q_in       (q_in)
  );

  shbe_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_in   (q_in),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  shbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .coeff_index (coeff_index),
    .basis_value (basis_value),
    .last_coeff  (last_coeff)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import shbe_pkg::*;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } direction_t;

  typedef struct packed {
    logic [3:0] idx;
    comp_t      value;
    logic       last_flag;
  } basis_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  comp_t      dir_x = '0;
  comp_t      dir_y = '0;
  comp_t      dir_z = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] coeff_index;
  comp_t      basis_value;
  logic       last_coeff;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data = '0;

  direction_t  dir_pending[$];
  basis_word_t basis_expect[$];
  logic [2:0]  band_setting = 3'd4;
  int          dirs_queued = 0;
  int          dirs_taken = 0;
  int          fail_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  sh_basis_eval_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .dir_z       (dir_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .coeff_index (coeff_index),
    .basis_value (basis_value),
    .last_coeff  (last_coeff),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // signed Q.24 scale per basis index, half/quarter factor and sign included
  function automatic longint sh_scale(input int k);
    case (k)
      0:  return 64'sd4732765;
      1:  return -64'sd8197390;
      2:  return 64'sd8197390;
      3:  return -64'sd8197390;
      4:  return 64'sd18329921;
      5:  return -64'sd18329921;
      6:  return 64'sd5291392;
      7:  return -64'sd18329921;
      8:  return 64'sd9164961;
      9:  return -64'sd9899289;
      10: return 64'sd48496413;
      11: return -64'sd7667956;
      12: return 64'sd6260860;
      13: return -64'sd7667956;
      14: return 64'sd24248206;
      default: return -64'sd9899289;
    endcase
  endfunction

  // q45 -> q30, half rounds up
  function automatic longint round_q45(input longint p);
    return (p + (64'sd1 <<< 14)) >>> 15;
  endfunction

  function automatic void predict_basis(input comp_t x, input comp_t y, input comp_t z,
                                        input logic [2:0] bands);
    longint      xl, yl, zl, xx, yy, zz, poly, r;
    int          nb, n;
    basis_word_t w;
    xl = x;
    yl = y;
    zl = z;
    xx = xl * xl;
    yy = yl * yl;
    zz = zl * zl;
    nb = bands;
    n = (nb > 4) ? 16 : nb * nb;
    for (int k = 0; k < n; k++) begin
      case (k)
        0:  poly = 64'sd1 <<< 30;
        1:  poly = yl * 32768;
        2:  poly = zl * 32768;
        3:  poly = xl * 32768;
        4:  poly = xl * yl;
        5:  poly = yl * zl;
        6:  poly = 2 * zz - xx - yy;
        7:  poly = zl * xl;
        8:  poly = xx - yy;
        9:  poly = round_q45((3 * xx - yy) * yl);
        10: poly = round_q45(xl * yl * zl);
        11: poly = round_q45(yl * (4 * zz - xx - yy));
        12: poly = round_q45(zl * (2 * zz - 3 * xx - 3 * yy));
        13: poly = round_q45(xl * (4 * zz - xx - yy));
        14: poly = round_q45((xx - yy) * zl);
        default: poly = round_q45((xx - 3 * yy) * xl);
      endcase
      r = (sh_scale(k) * poly + (64'sd1 <<< 38)) >>> 39;
      if (r > 32767) r = 32767;
      else if (r < -32768) r = -32768;
      w.idx = k[3:0];
      w.value = r[15:0];
      w.last_flag = (k == n - 1);
      basis_expect = {basis_expect, w};
    end
  endfunction

  function automatic comp_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return 16'sd0;
      3: return 16'sd1;
      4: return -16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic direction_t random_direction();
    direction_t d;
    real        a, b, c, mag;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        // roughly unit length, the case the block is built for
        a = real'(int'($urandom_range(0, 65534)) - 32767);
        b = real'(int'($urandom_range(0, 65534)) - 32767);
        c = real'(int'($urandom_range(0, 65534)) - 32767);
        mag = $sqrt(a * a + b * b + c * c);
        if (mag < 1.0) mag = 1.0;
        d.x = comp_t'($rtoi(a / mag * 32767.0));
        d.y = comp_t'($rtoi(b / mag * 32767.0));
        d.z = comp_t'($rtoi(c / mag * 32767.0));
      end
      6, 7: begin
        d.x = comp_t'($urandom);
        d.y = comp_t'($urandom);
        d.z = comp_t'($urandom);
      end
      8: begin
        d.x = pick_extreme();
        d.y = pick_extreme();
        d.z = pick_extreme();
      end
      default: begin
        d.x = comp_t'(int'($urandom_range(0, 511)) - 256);
        d.y = comp_t'(int'($urandom_range(0, 511)) - 256);
        d.z = comp_t'(int'($urandom_range(0, 511)) - 256);
      end
    endcase
    return d;
  endfunction

  task automatic queue_direction(input comp_t x, input comp_t y, input comp_t z);
    direction_t d;
    d.x = x;
    d.y = y;
    d.z = z;
    dir_pending = {dir_pending, d};
    dirs_queued++;
  endtask

  task automatic write_bands(input logic [2:0] bands);
    cfg_valid <= 1'b1;
    cfg_data <= bands;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    band_setting = bands;
  endtask

  // wait for every direction to be taken and every word to come back, then
  // let the pipe settle since zero-band directions leave nothing to wait on
  task automatic drain();
    @(posedge clk);
    while (dirs_taken != dirs_queued || basis_expect.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // sender: bursts of directions separated by random gaps
  always @(posedge clk) begin : send_proc
    direction_t d;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_basis(dir_x, dir_y, dir_z, band_setting);
        dirs_taken++;
      end
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (dir_pending.size() != 0) begin
        d = dir_pending.pop_front();
        in_valid <= 1'b1;
        dir_x <= d.x;
        dir_y <= d.y;
        dir_z <= d.z;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between free, light, alternating and heavy
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(16, 160);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_proc
    basis_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (basis_expect.size() == 0) begin
        $error("word with nothing expected: coeff_index %0d basis_value %0d",
               coeff_index, basis_value);
        fail_count++;
      end else begin
        w = basis_expect.pop_front();
        if (coeff_index !== w.idx) begin
          $error("coeff_index expected %0d actual %0d", w.idx, coeff_index);
          fail_count++;
        end
        if (basis_value !== w.value) begin
          $error("basis_value expected %0d actual %0d", w.value, basis_value);
          fail_count++;
        end
        if (last_coeff !== w.last_flag) begin
          $error("last_coeff expected %0d actual %0d", w.last_flag, last_coeff);
          fail_count++;
        end
      end
    end
  end

  initial begin : stim_proc
    int         phase_bands[9];
    int         phase_dirs[9];
    direction_t d;
    phase_bands = '{0, 7, 1, 2, 3, 5, 6, 4, 2};
    phase_dirs = '{4, 8, 12, 16, 20, 10, 6, 35, 6};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // four bands out of reset: axes, corners and the full-scale extremes
    queue_direction(16'sd0, 16'sd0, 16'sd0);
    queue_direction(16'sd32767, 16'sd0, 16'sd0);
    queue_direction(-16'sd32768, 16'sd0, 16'sd0);
    queue_direction(16'sd0, 16'sd32767, 16'sd0);
    queue_direction(16'sd0, -16'sd32768, 16'sd0);
    queue_direction(16'sd0, 16'sd0, 16'sd32767);
    queue_direction(16'sd0, 16'sd0, -16'sd32768);
    queue_direction(16'sd32767, 16'sd32767, 16'sd32767);
    queue_direction(-16'sd32768, -16'sd32768, -16'sd32768);
    queue_direction(16'sd32767, -16'sd32768, 16'sd32767);
    queue_direction(-16'sd32768, 16'sd32767, -16'sd32768);
    queue_direction(16'sd18919, 16'sd18919, 16'sd18919);
    queue_direction(16'sd23170, 16'sd0, -16'sd23170);
    queue_direction(-16'sd1, 16'sd1, -16'sd1);
    queue_direction(16'sd1, -16'sd1, 16'sd0);
    drain();

    // zero bands first, then above four, then the rest
    foreach (phase_bands[p]) begin
      write_bands(phase_bands[p][2:0]);
      for (int i = 0; i < phase_dirs[p]; i++) begin
        d = random_direction();
        queue_direction(d.x, d.y, d.z);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("** sh_basis_eval_unit: PASSED **");
    end else begin
      $display("** sh_basis_eval_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** sh_basis_eval_unit: FAILED **");
    $finish;
  end

endmodule
